// File: hw/rtl/bsfe_pkg.sv
// Shared types and constants for the byte stuffing frame encoder.
package bsfe_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned MAX_LEN_OK  = 253;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_CODE  = 2'd0,
    REG_ESCAPE_CODE = 2'd1,
    REG_START_SUB   = 2'd2,
    REG_ESCAPE_SUB  = 2'd3
  } cfg_idx_t;

  localparam logic [BYTE_W-1:0] START_CODE_RST  = 8'd254;
  localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST = 8'd253;
  localparam logic [BYTE_W-1:0] START_SUB_RST   = 8'd1;
  localparam logic [BYTE_W-1:0] ESCAPE_SUB_RST  = 8'd2;

  // Live configuration as seen by the emitter
  typedef struct packed {
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] escape_code;
    logic [BYTE_W-1:0] start_sub;
    logic [BYTE_W-1:0] escape_sub;
  } cfg_t;

  // One emit command per accepted item that produces output
  typedef struct packed {
    logic              err;    // single length error marker
    logic              hdr;    // start code before byte a
    logic              has_a;  // byte a is sent (stuffed)
    logic [BYTE_W-1:0] a;
    logic              has_b;  // checksum b is sent (stuffed), closes the frame
    logic [BYTE_W-1:0] b;
  } cmd_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic vld;
  } q_stat_t;

endpackage

// File: hw/rtl/byte_stuffing_frame_encoder_unit.sv
// Top level of the byte stuffing frame encoder: config registers, front, queue, emitter.
//
// Takes a raw message one byte per item (id, length, payload) and sends the
// framed stream: start code, id, payload and an XOR checksum, each id, payload
// or checksum byte that equals the start or escape code replaced by the escape
// code and a substitute. An item yields zero to four output bytes, and the
// emitter sends one byte per cycle while it holds a command and the output is
// not stalled. The front end classifies one item per cycle into a command queue
// of QUEUE_DEPTH entries and takes input whenever that queue has room; a length
// item with a nonzero length in range produces no command. The first output
// byte of an item passes through the queue, the command register and the
// output register. A declared length above 253 yields a single item with
// length_error set and out_byte zero, and the frame is left without a checksum.
module byte_stuffing_frame_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = bsfe_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bsfe_pkg::BYTE_W-1:0]         in_tdata,   // [7:0] in_byte
  // output stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bsfe_pkg::BYTE_W-1:0]         out_tdata,  // [7:0] out_byte
  output logic                                out_tlast,  // frame_end
  output logic [1:0]                          out_tuser,  // [0] length_error, [1] run_last
  // configuration
  input  logic                                cfg_we,
  input  logic [bsfe_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [bsfe_pkg::BYTE_W-1:0]         cfg_wdata
);

  bsfe_pkg::cfg_t    cfg_r, cfg_nxt;
  bsfe_pkg::q_stat_t q_stat;
  bsfe_pkg::cmd_t    push_cmd;
  bsfe_pkg::cmd_t    pop_cmd;
  logic              push;
  logic              pop;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (bsfe_pkg::cfg_idx_t'(cfg_idx))
        bsfe_pkg::REG_START_CODE:  cfg_nxt.start_code  = cfg_wdata;
        bsfe_pkg::REG_ESCAPE_CODE: cfg_nxt.escape_code = cfg_wdata;
        bsfe_pkg::REG_START_SUB:   cfg_nxt.start_sub   = cfg_wdata;
        bsfe_pkg::REG_ESCAPE_SUB:  cfg_nxt.escape_sub  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code  <= bsfe_pkg::START_CODE_RST;
      cfg_r.escape_code <= bsfe_pkg::ESCAPE_CODE_RST;
      cfg_r.start_sub   <= bsfe_pkg::START_SUB_RST;
      cfg_r.escape_sub  <= bsfe_pkg::ESCAPE_SUB_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bsfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  bsfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  bsfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_stat     (q_stat),
    .pop_cmd    (pop_cmd),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // Length error marker is a lone zero byte that ends its item's run
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tuser[1] && !out_tlast && out_tdata == '0))
    else $error("length error result malformed");

  // Frame end is always the final result of its item
  a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tuser[1])
    else $error("frame end not marked as last of item");

  // Emitter only takes commands that exist
  a_pop_vld: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.vld)
    else $error("pop from empty command queue");

  // Front never pushes into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("push into full command queue");

endmodule

// File: hw/rtl/bsfe_front.sv
// Front end: parses id/length/payload items and issues emit commands.
module bsfe_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bsfe_pkg::BYTE_W-1:0]         in_tdata,   // [7:0] in_byte
  input  bsfe_pkg::q_stat_t                   q_stat,
  output logic                                push,
  output bsfe_pkg::cmd_t                      push_cmd
);

  typedef enum logic [2:0] {
    PH_ID  = 3'b001,
    PH_LEN = 3'b010,
    PH_PAY = 3'b100
  } phase_t;

  phase_t                      phase_r, phase_nxt;
  logic [bsfe_pkg::BYTE_W-1:0] rem_r, rem_nxt;
  logic [bsfe_pkg::BYTE_W-1:0] xor_r, xor_nxt;
  logic [bsfe_pkg::BYTE_W-1:0] rem_dec;
  logic [bsfe_pkg::BYTE_W-1:0] xor_pay;
  logic                        accept;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign rem_dec   = rem_r - 1'b1;
  assign xor_pay   = xor_r ^ in_tdata;

  // Classify the item and build its command
  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    xor_nxt   = xor_r;
    push      = 1'b0;
    push_cmd  = '0;
    if (accept) begin
      case (phase_r)
        PH_LEN: begin
          if (in_tdata > bsfe_pkg::BYTE_W'(bsfe_pkg::MAX_LEN_OK)) begin
            push         = 1'b1;
            push_cmd.err = 1'b1;
            phase_nxt    = PH_ID;
            rem_nxt      = '0;
          end else if (in_tdata == '0) begin
            push           = 1'b1;
            push_cmd.has_b = 1'b1;
            push_cmd.b     = xor_r;
            phase_nxt      = PH_ID;
            rem_nxt        = '0;
          end else begin
            rem_nxt   = in_tdata;
            phase_nxt = PH_PAY;
          end
        end
        PH_PAY: begin
          push           = 1'b1;
          push_cmd.has_a = 1'b1;
          push_cmd.a     = in_tdata;
          xor_nxt        = xor_pay;
          rem_nxt        = rem_dec;
          if (rem_dec == '0) begin
            push_cmd.has_b = 1'b1;
            push_cmd.b     = xor_pay;
            phase_nxt      = PH_ID;
          end
        end
        default: begin
          // id byte; unknown phase codes behave the same
          push           = 1'b1;
          push_cmd.hdr   = 1'b1;
          push_cmd.has_a = 1'b1;
          push_cmd.a     = in_tdata;
          xor_nxt        = in_tdata;
          rem_nxt        = '0;
          phase_nxt      = PH_LEN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ID;
      rem_r   <= '0;
      xor_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      xor_r   <= xor_nxt;
    end
  end

endmodule

// File: hw/rtl/bsfe_queue.sv
// Small command queue between front end and emitter.
module bsfe_queue #(
  parameter int unsigned DEPTH = bsfe_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bsfe_pkg::cmd_t     push_cmd,
  input  logic               pop,
  output bsfe_pkg::cmd_t     pop_cmd,
  output bsfe_pkg::q_stat_t  q_stat
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bsfe_pkg::cmd_t  mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign q_stat.full = (cnt_r == CW'(DEPTH));
  assign q_stat.vld  = (cnt_r != '0);
  assign do_push     = push && !q_stat.full;
  assign do_pop      = pop && q_stat.vld;
  assign pop_cmd     = mem[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: hw/rtl/bsfe_back.sv
// Emitter: expands commands into stuffed output bytes, one per cycle while the output is not stalled.
module bsfe_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bsfe_pkg::cfg_t               cfg,
  input  bsfe_pkg::q_stat_t            q_stat,
  input  bsfe_pkg::cmd_t               pop_cmd,
  output logic                         pop,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [bsfe_pkg::BYTE_W-1:0]  out_tdata,  // [7:0] out_byte
  output logic                         out_tlast,  // frame_end
  output logic [1:0]                   out_tuser   // [0] length_error, [1] run_last
);

  typedef enum logic [5:0] {
    ST_HDR = 6'b000001,
    ST_A   = 6'b000010,
    ST_A2  = 6'b000100,
    ST_B   = 6'b001000,
    ST_B2  = 6'b010000,
    ST_ERR = 6'b100000
  } step_t;

  bsfe_pkg::cmd_t              cur_r, cur_nxt;
  logic                        cur_vld_r, cur_vld_nxt;
  step_t                       step_r, step_nxt, step_adv, step_first;
  logic                        out_vld_r, out_vld_nxt;
  logic [bsfe_pkg::BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic                        out_fe_r, out_fe_nxt;
  logic                        out_lerr_r, out_lerr_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        emit_en;
  logic [bsfe_pkg::BYTE_W-1:0] sel_byte;
  logic                        is_start;
  logic                        is_escape;
  logic [bsfe_pkg::BYTE_W-1:0] sub_byte;
  logic [bsfe_pkg::BYTE_W-1:0] e_byte;
  logic                        e_fe;
  logic                        e_lerr;
  logic                        e_last;

  assign emit_en = cur_vld_r && (!out_vld_r || out_tready);
  assign pop     = q_stat.vld && (!cur_vld_r || (emit_en && e_last));

  // Stuffing test on the byte this step works on
  assign sel_byte  = ((step_r == ST_A) || (step_r == ST_A2)) ? cur_r.a : cur_r.b;
  assign is_start  = (sel_byte == cfg.start_code);
  assign is_escape = (sel_byte == cfg.escape_code);
  assign sub_byte  = is_start ? cfg.start_sub : cfg.escape_sub;

  // First step of a newly loaded command
  always_comb begin
    if (pop_cmd.err) begin
      step_first = ST_ERR;
    end else if (pop_cmd.hdr) begin
      step_first = ST_HDR;
    end else if (pop_cmd.has_a) begin
      step_first = ST_A;
    end else begin
      step_first = ST_B;
    end
  end

  // Byte produced by the current step and the step after it
  always_comb begin
    e_byte   = '0;
    e_fe     = 1'b0;
    e_lerr   = 1'b0;
    e_last   = 1'b0;
    step_adv = step_r;
    case (step_r)
      ST_HDR: begin
        e_byte   = cfg.start_code;
        step_adv = cur_r.has_a ? ST_A : ST_B;
      end
      ST_A: begin
        if (is_start || is_escape) begin
          e_byte   = cfg.escape_code;
          step_adv = ST_A2;
        end else begin
          e_byte   = cur_r.a;
          step_adv = ST_B;
          e_last   = !cur_r.has_b;
        end
      end
      ST_A2: begin
        e_byte   = sub_byte;
        step_adv = ST_B;
        e_last   = !cur_r.has_b;
      end
      ST_B: begin
        if (is_start || is_escape) begin
          e_byte   = cfg.escape_code;
          step_adv = ST_B2;
        end else begin
          e_byte = cur_r.b;
          e_fe   = 1'b1;
          e_last = 1'b1;
        end
      end
      ST_B2: begin
        e_byte = sub_byte;
        e_fe   = 1'b1;
        e_last = 1'b1;
      end
      ST_ERR: begin
        e_lerr = 1'b1;
        e_last = 1'b1;
      end
      default: begin
        e_last = 1'b1;
      end
    endcase
  end

  // Command register and step sequencing
  always_comb begin
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    step_nxt    = step_r;
    if (pop) begin
      cur_nxt     = pop_cmd;
      cur_vld_nxt = 1'b1;
      step_nxt    = step_first;
    end else if (emit_en && e_last) begin
      cur_vld_nxt = 1'b0;
    end else if (emit_en) begin
      step_nxt = step_adv;
    end
  end

  // Output register
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_byte_nxt = out_byte_r;
    out_fe_nxt   = out_fe_r;
    out_lerr_nxt = out_lerr_r;
    out_last_nxt = out_last_r;
    if (emit_en) begin
      out_vld_nxt  = 1'b1;
      out_byte_nxt = e_byte;
      out_fe_nxt   = e_fe;
      out_lerr_nxt = e_lerr;
      out_last_nxt = e_last;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      step_r    <= ST_HDR;
      out_vld_r <= 1'b0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      step_r    <= step_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_byte_r <= out_byte_nxt;
    out_fe_r   <= out_fe_nxt;
    out_lerr_r <= out_lerr_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_fe_r;
  assign out_tuser  = {out_last_r, out_lerr_r};

endmodule
